// ===== design/itbd_pkg.sv =====
// Package for integer_to_base_digits: sizes, config register indexes,
// reciprocal table for the digit divider and the sequencer microcode ROM.
// No dependencies.
`default_nettype none

package itbd_pkg;

    localparam int MAX_BASE_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int SYM_W        = 8;
    localparam int BASE_W       = 5;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int DIG_DEPTH    = 32;                  // most digits of a 32-bit magnitude
    localparam int DIG_AW       = $clog2(DIG_DEPTH);
    localparam int CNT_W        = DIG_AW + 1;
    localparam int STEP_W       = 3;
    localparam int REM_W        = 6;                   // remainder estimate stays below 32

    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BASE_W-1:0] MIN_RADIX = 5'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_HIGH = 2'd2;

    localparam logic [BASE_W-1:0]  RST_BASE_SIZE   = 5'd10;
    localparam logic [CFG_W-1:0]   RST_DIGITS_LOW  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0]   RST_DIGITS_HIGH = 64'h0000_0000_0000_3938;

    // program step addresses
    localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] ST_CHECK = 3'd1;
    localparam logic [STEP_W-1:0] ST_MUL   = 3'd2;
    localparam logic [STEP_W-1:0] ST_FIX   = 3'd3;
    localparam logic [STEP_W-1:0] ST_SIGN  = 3'd4;
    localparam logic [STEP_W-1:0] ST_EMIT  = 3'd5;

    typedef enum logic [2:0] {
        C_NONE,      // never jump
        C_ACCEPT,    // an input beat was taken
        C_BAD,       // alphabet rejected
        C_QNZ,       // corrected quotient still nonzero
        C_POS,       // value was not negative
        C_LAST       // emitting the final digit
    } t_cond;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_SIGN,
        EM_DIGIT
    } t_emit;

    typedef struct packed {
        logic              ready;   // input channel open
        logic              mul;     // load quotient estimate
        logic              fix;     // correct quotient, store digit
        t_emit             emit;
        t_cond             cond;
        logic [STEP_W-1:0] target;
        logic              hold;    // stay on this step when the jump is not taken
    } t_uword;

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{ready: 1'b0, mul: 1'b0, fix: 1'b0, emit: EM_NONE,
              cond: C_NONE, target: ST_IDLE, hold: 1'b0};
        case (step)
            ST_IDLE: begin
                w.ready  = 1'b1;
                w.cond   = C_ACCEPT;
                w.target = ST_CHECK;
                w.hold   = 1'b1;
            end
            ST_CHECK: begin
                w.cond   = C_BAD;
                w.target = ST_IDLE;
            end
            ST_MUL: begin
                w.mul    = 1'b1;
            end
            ST_FIX: begin
                w.fix    = 1'b1;
                w.cond   = C_QNZ;
                w.target = ST_MUL;
            end
            ST_SIGN: begin
                w.emit   = EM_SIGN;
                w.cond   = C_POS;
                w.target = ST_EMIT;
            end
            ST_EMIT: begin
                w.emit   = EM_DIGIT;
                w.cond   = C_LAST;
                w.target = ST_IDLE;
                w.hold   = 1'b1;
            end
            default: begin
                w.target = ST_IDLE;
                w.cond   = C_NONE;
                w.hold   = 1'b0;
            end
        endcase
        return w;
    endfunction

    // floor(2^32 / d); estimate q' = (m * recip) >> 32 is q or q - 1
    function automatic logic [VALUE_W-1:0] recip(input logic [BASE_W-1:0] d);
        logic [VALUE_W-1:0] r;
        case (d)
            5'd2:    r = 32'h8000_0000;
            5'd3:    r = 32'h5555_5555;
            5'd4:    r = 32'h4000_0000;
            5'd5:    r = 32'h3333_3333;
            5'd6:    r = 32'h2AAA_AAAA;
            5'd7:    r = 32'h2492_4924;
            5'd8:    r = 32'h2000_0000;
            5'd9:    r = 32'h1C71_C71C;
            5'd10:   r = 32'h1999_9999;
            5'd11:   r = 32'h1745_D174;
            5'd12:   r = 32'h1555_5555;
            5'd13:   r = 32'h13B1_3B13;
            5'd14:   r = 32'h1249_2492;
            5'd15:   r = 32'h1111_1111;
            5'd16:   r = 32'h1000_0000;
            default: r = 32'hFFFF_FFFF;   // radix rejected before use
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/integer_to_base_digits.sv =====
// Top level of integer_to_base_digits: signed integer to text in a configured radix.
// Microcoded sequencer over a reciprocal-multiply digit divider; uses itbd_pkg.
//
// Usage: one signed 32-bit value enters on the input channel (i_valid/o_stall) and
// leaves as a run of symbol beats on the output channel (o_valid/i_stall), a '-'
// first for negative values, then digits most significant first, o_last on the
// final beat. A rejected alphabet (radix below 2 or above MAX_BASE, a '+' or '-'
// symbol, a repeated symbol) yields no beats at all.
// Sequence for a value: the alphabet check, then for each digit a divider pass (a
// 32x32 reciprocal multiply step, then a remainder correction step), then the sign
// step and the digit beats, each beat held while the receiver stalls. The next
// value is taken as soon as the last beat sits in the output register. Config
// writes are registered; the user must make config writes only while idle, as the
// block itself does not enforce it.
// Reset restores the decimal alphabet "0123456789" and empties the output register.
// A stalling receiver holds the output register and freezes the sequencer on its
// emit step; the payload does not change while stalled.
`default_nettype none

module integer_to_base_digits
    import itbd_pkg::*;
#(
    parameter int MAX_BASE = MAX_BASE_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [CFG_W-1:0]            i_cfg_data,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic signed [VALUE_W-1:0]   i_value,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [SYM_W-1:0]                 o_symbol,
    output logic                             o_last
);

    localparam int DIGIT_W = (MAX_BASE > 1) ? $clog2(MAX_BASE) : 1;

    logic [BASE_W-1:0]      r_base;
    logic [CFG_W-1:0]       r_dig_lo;
    logic [CFG_W-1:0]       r_dig_hi;

    logic [STEP_W-1:0]      r_step, n_step;
    logic [VALUE_W-1:0]     r_mag;
    logic [VALUE_W-1:0]     r_q;
    logic                   r_neg;
    logic [CNT_W-1:0]       r_nd;
    logic [DIGIT_W-1:0]     r_digits [DIG_DEPTH];

    logic                   r_ovalid;
    logic [SYM_W-1:0]       r_osym;
    logic                   r_olast;

    t_uword                 w_uw;
    logic [2*CFG_W-1:0]     w_alpha_bits;
    logic [SYM_W-1:0]       w_sym [MAX_BASE];
    logic                   w_alpha_ok;
    logic [2*VALUE_W-1:0]   w_prod;
    logic [REM_W-1:0]       w_rem;
    logic [REM_W-1:0]       w_qd;
    logic                   w_over;
    logic [VALUE_W-1:0]     w_qfix;
    logic [DIGIT_W-1:0]     w_digit;
    logic                   w_cond;
    logic                   w_emit;
    logic                   w_out_free;
    logic                   w_block;
    logic                   w_accept;
    logic [CNT_W-1:0]       w_nd_dec;
    logic [DIGIT_W-1:0]     w_rd_digit;
    logic [SYM_W-1:0]       w_emit_sym;

    // alphabet bytes
    assign w_alpha_bits = {r_dig_hi, r_dig_lo};

    always_comb begin
        for (int k = 0; k < MAX_BASE; k++) begin
            w_sym[k] = w_alpha_bits[k*SYM_W +: SYM_W];
        end
    end

    // alphabet check: all pairs compared in parallel
    always_comb begin
        w_alpha_ok = (r_base >= MIN_RADIX) && ({27'd0, r_base} <= MAX_BASE);
        for (int i = 0; i < MAX_BASE; i++) begin
            if (i < int'(r_base)) begin
                if (w_sym[i] == CHAR_PLUS || w_sym[i] == CHAR_MINUS) begin
                    w_alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_BASE; j++) begin
                    if (j < int'(r_base) && w_sym[j] == w_sym[i]) begin
                        w_alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // digit divider: estimate, then one correction from the low remainder bits
    assign w_prod  = {{VALUE_W{1'b0}}, r_mag} * {{VALUE_W{1'b0}}, recip(r_base)};
    assign w_qd    = REM_W'(r_q[REM_W-1:0] * {1'b0, r_base});
    assign w_rem   = r_mag[REM_W-1:0] - w_qd;
    assign w_over  = (w_rem >= {1'b0, r_base});
    assign w_qfix  = r_q + {{(VALUE_W-1){1'b0}}, w_over};
    assign w_digit = w_over ? DIGIT_W'(w_rem - {1'b0, r_base}) : DIGIT_W'(w_rem);

    assign w_nd_dec   = r_nd - CNT_W'(1);
    assign w_rd_digit = r_digits[w_nd_dec[DIG_AW-1:0]];
    assign w_emit_sym = (w_uw.emit == EM_SIGN) ? CHAR_MINUS : w_sym[w_rd_digit];

    // sequencer
    always_comb begin
        w_uw = ucode(r_step);
        case (w_uw.cond)
            C_NONE:   w_cond = 1'b0;
            C_ACCEPT: w_cond = i_valid;
            C_BAD:    w_cond = !w_alpha_ok;
            C_QNZ:    w_cond = (w_qfix != '0);
            C_POS:    w_cond = !r_neg;
            C_LAST:   w_cond = (r_nd == CNT_W'(1));
            default:  w_cond = 1'b0;
        endcase
        w_emit     = (w_uw.emit == EM_DIGIT) || (w_uw.emit == EM_SIGN && r_neg);
        w_out_free = !r_ovalid || !i_stall;
        w_block    = w_emit && !w_out_free;
        w_accept   = w_uw.ready && i_valid;
        if (w_block) begin
            n_step = r_step;
        end else if (w_cond) begin
            n_step = w_uw.target;
        end else if (w_uw.hold) begin
            n_step = r_step;
        end else begin
            n_step = r_step + STEP_W'(1);
        end
    end

    // closed while reset is held
    assign o_stall = !w_uw.ready || !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_base   <= RST_BASE_SIZE;
            r_dig_lo <= RST_DIGITS_LOW;
            r_dig_hi <= RST_DIGITS_HIGH;
        end else begin
            r_step <= n_step;
            if (w_emit && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE_SIZE:   r_base   <= i_cfg_data[BASE_W-1:0];
                    CFG_DIGITS_LOW:  r_dig_lo <= i_cfg_data;
                    CFG_DIGITS_HIGH: r_dig_hi <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg <= i_value[VALUE_W-1];
            r_mag <= i_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(i_value))
                                        : VALUE_W'(i_value);
            r_nd  <= '0;
        end
        if (w_uw.mul) begin
            r_q <= w_prod[2*VALUE_W-1:VALUE_W];
        end
        if (w_uw.fix) begin
            r_mag <= w_qfix;
            r_digits[r_nd[DIG_AW-1:0]] <= w_digit;
            r_nd  <= r_nd + CNT_W'(1);
        end
        if (w_emit && w_out_free) begin
            r_osym  <= w_emit_sym;
            r_olast <= (w_uw.emit == EM_DIGIT) && (r_nd == CNT_W'(1));
            if (w_uw.emit == EM_DIGIT) begin
                r_nd <= w_nd_dec;
            end
        end
    end

    assign o_valid  = r_ovalid;
    assign o_symbol = r_osym;
    assign o_last   = r_olast;

endmodule

`default_nettype wire
